// ===== src/frl_pkg.sv =====
package frl_pkg;

  // Table geometry
  localparam int MAX_RULES = 64;
  localparam int IDX_W     = $clog2(MAX_RULES);
  localparam int CNT_W     = $clog2(MAX_RULES + 1);

  // Operation codes on the input channel
  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_QUERY  = 2'd2,
    FN_NOP    = 2'd3
  } frl_func_e;

  // Status codes on the result channel
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_BAD_IDX = 2'd2
  } frl_status_e;

  // What a token does as it walks the cell chain
  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_GATHER = 2'd1,
    OP_WRITE  = 2'd2
  } frl_op_e;

  // Controller sequencing
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MOVE = 2'd1,
    ST_SCAN = 2'd2
  } frl_state_e;

  // Token handed from cell to cell. For a query the address sits in addr_lo
  // and the port in port_lo; for gather and write the fields carry a rule.
  typedef struct packed {
    logic              valid;
    frl_op_e           op;
    logic [31:0]       addr_lo;
    logic [31:0]       addr_hi;
    logic [15:0]       port_lo;
    logic [15:0]       port_hi;
    logic [IDX_W-1:0]  tgt;
    logic [CNT_W-1:0]  cnt;
    logic              hit;
    logic              allowed;
    logic [IDX_W-1:0]  hit_idx;
  } frl_tok_t;

endpackage

// ===== src/firewall_rule_table_lookup.sv =====
// Firewall rule table with first-match lookup.
// Input channel: in_valid_i / in_stall_o with func_i and the rule, remove
// and query fields. Output channel: out_valid_o / out_stall_i with one
// result item per input item (allowed, rule_hit, hit_index, status,
// count_now). An item moves when valid is high and stall is low.
// Rules live in a chain of MAX_RULES cells, one rule per cell. Each item
// becomes a token that walks the chain one cell per cycle, so:
//   query, add           : one pass through the chain from accept to result
//   remove               : two passes through the chain; a gather pass
//                          fetches the last rule, a write pass stores it
//   table full, bad index, unused func : answered without a chain pass
// One item is in flight at a time; the next can be taken in the cycle the
// result appears, but only while the result register is free or being emptied,
// so a stalled result blocks the next item and holds in the output register.
// Reset empties the table (count 0) and clears all handshake state; the rule
// cells themselves are not cleared.
module firewall_rule_table_lookup import frl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] rule_addr_low_i,
  input  logic [31:0] rule_addr_high_i,
  input  logic [15:0] rule_port_low_i,
  input  logic [15:0] rule_port_high_i,
  input  logic [5:0]  remove_index_i,
  input  logic [31:0] query_address_i,
  input  logic [15:0] query_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        allowed_o,
  output logic        rule_hit_o,
  output logic [5:0]  hit_index_o,
  output logic [1:0]  status_o,
  output logic [6:0]  count_now_o
);

  frl_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  frl_func_e        func_q, func_d;
  logic [IDX_W-1:0] rm_idx_q, rm_idx_d;
  frl_tok_t         inj_q, inj_d;
  frl_tok_t         chain [MAX_RULES+1];
  frl_tok_t         exit_tok;
  logic             accept;
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             res_allowed_q, res_allowed_d;
  logic             res_hit_q, res_hit_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  frl_status_e      res_status_q, res_status_d;
  logic [CNT_W-1:0] res_cnt_q, res_cnt_d;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Cell chain
  assign chain[0] = inj_q;
  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    frl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_idx_i(IDX_W'(g)),
      .tok_i     (chain[g]),
      .tok_o     (chain[g+1])
    );
  end
  assign exit_tok = chain[MAX_RULES];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (frl_func_e'(func_i))
            FN_ADD: begin
              if (count_q < CNT_W'(MAX_RULES)) state_d = ST_SCAN;
            end
            FN_REMOVE: begin
              if (CNT_W'(remove_index_i) < count_q) state_d = ST_MOVE;
            end
            FN_QUERY: state_d = ST_SCAN;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MOVE: begin
        if (exit_tok.valid) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (exit_tok.valid) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Token injection, count update and result capture
  always_comb begin
    inj_d         = '0;
    count_d       = count_q;
    func_d        = func_q;
    rm_idx_d      = rm_idx_q;
    out_load      = 1'b0;
    res_allowed_d = 1'b0;
    res_hit_d     = 1'b0;
    res_idx_d     = '0;
    res_status_d  = STS_OK;
    res_cnt_d     = count_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d   = frl_func_e'(func_i);
          rm_idx_d = IDX_W'(remove_index_i);
          case (frl_func_e'(func_i))
            FN_ADD: begin
              if (count_q >= CNT_W'(MAX_RULES)) begin
                out_load     = 1'b1;
                res_status_d = STS_FULL;
              end else begin
                inj_d.valid   = 1'b1;
                inj_d.op      = OP_WRITE;
                inj_d.addr_lo = rule_addr_low_i;
                inj_d.addr_hi = rule_addr_high_i;
                inj_d.port_lo = rule_port_low_i;
                inj_d.port_hi = rule_port_high_i;
                inj_d.tgt     = count_q[IDX_W-1:0];
                inj_d.cnt     = count_q;
              end
            end
            FN_REMOVE: begin
              if (CNT_W'(remove_index_i) >= count_q) begin
                out_load     = 1'b1;
                res_status_d = STS_BAD_IDX;
              end else begin
                inj_d.valid = 1'b1;
                inj_d.op    = OP_GATHER;
                inj_d.tgt   = IDX_W'(count_q - CNT_W'(1));
                inj_d.cnt   = count_q;
              end
            end
            FN_QUERY: begin
              inj_d.valid   = 1'b1;
              inj_d.op      = OP_QUERY;
              inj_d.addr_lo = query_address_i;
              inj_d.port_lo = query_port_i;
              inj_d.cnt     = count_q;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_MOVE: begin
        // gathered last rule goes back in as a write to the removed slot
        if (exit_tok.valid) begin
          inj_d       = exit_tok;
          inj_d.valid = 1'b1;
          inj_d.op    = OP_WRITE;
          inj_d.tgt   = rm_idx_q;
        end
      end
      ST_SCAN: begin
        if (exit_tok.valid) begin
          out_load = 1'b1;
          case (func_q)
            FN_ADD:    count_d = count_q + CNT_W'(1);
            FN_REMOVE: count_d = count_q - CNT_W'(1);
            default: begin
              res_allowed_d = exit_tok.allowed;
              res_hit_d     = exit_tok.hit;
              res_idx_d     = exit_tok.hit_idx;
            end
          endcase
          res_cnt_d = count_d;
        end
      end
      default: begin
        inj_d = '0;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      inj_q       <= inj_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pending item and result payload
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    rm_idx_q <= rm_idx_d;
    if (out_load) begin
      res_allowed_q <= res_allowed_d;
      res_hit_q     <= res_hit_d;
      res_idx_q     <= res_idx_d;
      res_status_q  <= res_status_d;
      res_cnt_q     <= res_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign allowed_o   = res_allowed_q;
  assign rule_hit_o  = res_hit_q;
  assign hit_index_o = 6'(res_idx_q);
  assign status_o    = res_status_q;
  assign count_now_o = 7'(res_cnt_q);

  // A token leaves the chain only while a chained item is in flight
  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_tok.valid |-> (state_q == ST_MOVE || state_q == ST_SCAN))
    else $error("token left chain while idle");

  // Table never holds more than its capacity
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RULES))
    else $error("rule count above capacity");

  // A result is never written over one still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten");

  // Count moves only when a chained add or remove completes
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == ST_SCAN && exit_tok.valid) |=> count_q == $past(count_q))
    else $error("count changed outside completion");

  // An accepted query always starts a scan
  a_query_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FN_QUERY) |=> state_q == ST_SCAN)
    else $error("query did not start scan");

endmodule

// ===== src/frl_cell.sv =====
module frl_cell import frl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  frl_tok_t         tok_i,
  output frl_tok_t         tok_o
);

  logic [31:0] addr_lo_q, addr_lo_d;
  logic [31:0] addr_hi_q, addr_hi_d;
  logic [15:0] port_lo_q, port_lo_d;
  logic [15:0] port_hi_q, port_hi_d;
  logic        tok_valid_q;
  frl_tok_t    tok_d, tok_q;
  logic        in_table;
  logic        range_ok;
  logic        addr_match;
  logic        port_ok;

  // Per-octet range test of the query against this rule
  always_comb begin
    range_ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (tok_i.addr_lo[8*k +: 8] < addr_lo_q[8*k +: 8] ||
          tok_i.addr_lo[8*k +: 8] > addr_hi_q[8*k +: 8]) begin
        range_ok = 1'b0;
      end
    end
  end

  assign in_table   = CNT_W'(cell_idx_i) < tok_i.cnt;
  assign addr_match = (addr_lo_q == tok_i.addr_lo) ||
                      ((addr_hi_q != 32'd0) && range_ok);
  assign port_ok    = (port_lo_q == tok_i.port_lo) ||
                      ((port_hi_q != 16'd0) && (port_lo_q <= tok_i.port_lo) &&
                       (tok_i.port_lo <= port_hi_q));

  // Token processing and rule update
  always_comb begin
    tok_d     = tok_i;
    addr_lo_d = addr_lo_q;
    addr_hi_d = addr_hi_q;
    port_lo_d = port_lo_q;
    port_hi_d = port_hi_q;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_QUERY: begin
          if (!tok_i.hit && in_table && addr_match) begin
            tok_d.hit     = 1'b1;
            tok_d.hit_idx = cell_idx_i;
            tok_d.allowed = port_ok;
          end
        end
        OP_GATHER: begin
          if (cell_idx_i == tok_i.tgt) begin
            tok_d.addr_lo = addr_lo_q;
            tok_d.addr_hi = addr_hi_q;
            tok_d.port_lo = port_lo_q;
            tok_d.port_hi = port_hi_q;
          end
        end
        OP_WRITE: begin
          if (cell_idx_i == tok_i.tgt) begin
            addr_lo_d = tok_i.addr_lo;
            addr_hi_d = tok_i.addr_hi;
            port_lo_d = tok_i.port_lo;
            port_hi_d = tok_i.port_hi;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  // Rule storage, no reset
  always_ff @(posedge clk_i) begin
    addr_lo_q <= addr_lo_d;
    addr_hi_q <= addr_hi_d;
    port_lo_q <= port_lo_d;
    port_hi_q <= port_hi_d;
    tok_q     <= tok_d;
  end

  // Token valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_d.valid;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule
